/* rtl/core/ptc_pkg.sv */
package ptc_pkg;

	// Port and calibration widths
	localparam int RAW_W        = 24;
	localparam int ADC_BITS_DEF = 24;
	localparam int CAL_W        = 16;
	localparam int IDX_W        = 3;
	localparam int TEMP_W       = 12;
	localparam int PRES_W       = 16;

	// Internal datapath widths, sized to the worst-case range of each value
	localparam int DT_W      = 26;
	localparam int MUL_W     = DT_W + CAL_W + 1;
	localparam int T_W       = 20;
	localparam int OFF_W     = 38;
	localparam int SENS_W    = 38;
	localparam int SENS_LO_W = 19;
	localparam int SQ_W      = 35;
	localparam int DTSQ_W    = 48;
	localparam int TI_W      = 17;
	localparam int OFFI_W    = 36;
	localparam int SENSI_W   = 35;
	localparam int P_MAG_W   = 22;

	// Reference point of the second-order correction, 20.00 C
	localparam logic signed [T_W-1:0] T_REF = 20'sd2000;

	// Divide by 100 as multiply by ceil(2^29 / 100), exact for inputs below 2^22
	localparam int                 RECIP_W    = 23;
	localparam int                 RECIP_SH   = 29;
	localparam logic [RECIP_W-1:0] RECIP_100  = 23'd5368710;

	// Pressure in 0.01 mbar limited so that the quotient lands on the output bounds
	localparam int P_CLAMP_HI = 3276799;
	localparam int P_CLAMP_LO = -3276899;

	typedef enum logic [IDX_W-1:0] {
		REG_SENS       = 3'd0,
		REG_OFFSET     = 3'd1,
		REG_SENS_TC    = 3'd2,
		REG_OFFSET_TC  = 3'd3,
		REG_REF_TEMP   = 3'd4,
		REG_TEMP_SLOPE = 3'd5
	} ptc_reg_t;

	typedef struct packed {
		logic [CAL_W-1:0] sens;
		logic [CAL_W-1:0] offset;
		logic [CAL_W-1:0] sens_tc;
		logic [CAL_W-1:0] offset_tc;
		logic [CAL_W-1:0] ref_temp;
		logic [CAL_W-1:0] temp_slope;
	} ptc_cal_t;

	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [T_W-1:0]    t;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
		logic                     cold;
	} ptc_mid_t;

endpackage

/* rtl/core/ptc_cfg_regs.sv */
module ptc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ptc_pkg::IDX_W-1:0]  index,
	input  logic [ptc_pkg::CAL_W-1:0]  data,
	output ptc_pkg::ptc_cal_t          cal
);
	import ptc_pkg::*;

	ptc_cal_t cal_q;

	// Write one calibration word; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (ptc_reg_t'(index))
				REG_SENS:       cal_q.sens       <= data;
				REG_OFFSET:     cal_q.offset     <= data;
				REG_SENS_TC:    cal_q.sens_tc    <= data;
				REG_OFFSET_TC:  cal_q.offset_tc  <= data;
				REG_REF_TEMP:   cal_q.ref_temp   <= data;
				REG_TEMP_SLOPE: cal_q.temp_slope <= data;
				default: ;
			endcase
		end
	end

	assign cal = cal_q;

endmodule

/* rtl/core/ptc_front.sv */
module ptc_front #(
	parameter int ADC_BITS = ptc_pkg::ADC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ptc_pkg::RAW_W-1:0]  raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0]  raw_temperature,
	input  ptc_pkg::ptc_cal_t          cal,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ptc_pkg::ptc_mid_t          mid
);
	import ptc_pkg::*;

	localparam int T_SH         = 23;
	localparam int OFF_SH       = 8;
	localparam int SENS_SH      = 7;
	localparam int REF_SH       = 8;
	localparam int OFF_BASE_SH  = 17;
	localparam int SENS_BASE_SH = 16;
	localparam int TI_SH        = 35;
	localparam int OFFI_SH      = 3;
	localparam int SENSI_SH     = 5;
	localparam int TIF_W        = DTSQ_W + 4;
	localparam int OFFIF_W      = SQ_W + 5;
	localparam int SENSIF_W     = SQ_W + 6;

	localparam logic signed [MUL_W-1:0] T_RND    = MUL_W'((1 << T_SH) - 1);
	localparam logic signed [MUL_W-1:0] OFF_RND  = MUL_W'((1 << OFF_SH) - 1);
	localparam logic signed [MUL_W-1:0] SENS_RND = MUL_W'((1 << SENS_SH) - 1);
	localparam logic signed [MUL_W-1:0] M_ZERO   = MUL_W'(0);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic [ADC_BITS-1:0] d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [DT_W-1:0] dt_c, dt_s1, dt_s2, dt_s3;
	logic signed [MUL_W-1:0] p6_s2, p4_s2, p3_s2;
	logic signed [MUL_W-1:0] p6_adj, p4_adj, p3_adj;
	logic signed [T_W-1:0] t_c, t_s3, t_s4, t_s5, t_s6;
	logic signed [OFF_W-1:0] off_c, off_s3, off_s4, off_s5, off_s6;
	logic signed [SENS_W-1:0] sens_c, sens_s3, sens_s4, sens_s5, sens_s6;
	logic signed [T_W:0] delta_c;
	logic signed [2*T_W+1:0] sqf_c;
	logic signed [2*DT_W-1:0] dtsqf_c;
	logic [SQ_W-1:0] sq_s4;
	logic [DTSQ_W-1:0] dtsq_s4;
	logic cold_s4, cold_s5, cold_s6;
	logic [TIF_W-1:0] tif_c;
	logic [OFFIF_W-1:0] offif_c;
	logic [SENSIF_W-1:0] sensif_c;
	logic [TI_W-1:0] ti_s5;
	logic [OFFI_W-1:0] offi_s5;
	logic [SENSI_W-1:0] sensi_s5;

	// Advance a stage when it is empty or the next one advances
	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: dT = D2 - C5 * 2^8
	assign dt_c = $signed(DT_W'(raw_temperature[ADC_BITS-1:0]))
		- $signed(DT_W'({cal.ref_temp, {REF_SH{1'b0}}}));

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d1_s1 <= raw_pressure[ADC_BITS-1:0];
			dt_s1 <= dt_c;
		end
	end

	// Stage 2: first-order products of dT
	always_ff @(posedge clk) begin
		if (en_s2) begin
			d1_s2 <= d1_s1;
			dt_s2 <= dt_s1;
			p6_s2 <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, cal.temp_slope}));
			p4_s2 <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, cal.offset_tc}));
			p3_s2 <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, cal.sens_tc}));
		end
	end

	// Stage 3: TEMP, OFF, SENS with shifts truncated toward zero
	assign p6_adj = p6_s2 + (p6_s2[MUL_W-1] ? T_RND : M_ZERO);
	assign p4_adj = p4_s2 + (p4_s2[MUL_W-1] ? OFF_RND : M_ZERO);
	assign p3_adj = p3_s2 + (p3_s2[MUL_W-1] ? SENS_RND : M_ZERO);

	assign t_c    = T_REF + T_W'(p6_adj >>> T_SH);
	assign off_c  = $signed(OFF_W'({cal.offset, {OFF_BASE_SH{1'b0}}}))
		+ OFF_W'(p4_adj >>> OFF_SH);
	assign sens_c = $signed(SENS_W'({cal.sens, {SENS_BASE_SH{1'b0}}}))
		+ SENS_W'(p3_adj >>> SENS_SH);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			d1_s3   <= d1_s2;
			dt_s3   <= dt_s2;
			t_s3    <= t_c;
			off_s3  <= off_c;
			sens_s3 <= sens_c;
		end
	end

	// Stage 4: squares for the cold correction
	assign delta_c = (T_W+1)'(t_s3) - (T_W+1)'(T_REF);
	assign sqf_c   = (2*T_W+2)'(delta_c) * (2*T_W+2)'(delta_c);
	assign dtsqf_c = (2*DT_W)'(dt_s3) * (2*DT_W)'(dt_s3);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			d1_s4   <= d1_s3;
			t_s4    <= t_s3;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
			cold_s4 <= t_s3 < T_REF;
			sq_s4   <= sqf_c[SQ_W-1:0];
			dtsq_s4 <= dtsqf_c[DTSQ_W-1:0];
		end
	end

	// Stage 5: correction terms 11*dT^2/2^35, 31*d^2/2^3, 63*d^2/2^5
	assign tif_c    = TIF_W'({dtsq_s4, 3'b000}) + TIF_W'({dtsq_s4, 1'b0})
		+ TIF_W'(dtsq_s4);
	assign offif_c  = OFFIF_W'({sq_s4, 5'b00000}) - OFFIF_W'(sq_s4);
	assign sensif_c = SENSIF_W'({sq_s4, 6'b000000}) - SENSIF_W'(sq_s4);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			d1_s5    <= d1_s4;
			t_s5     <= t_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			cold_s5  <= cold_s4;
			ti_s5    <= tif_c[TI_SH +: TI_W];
			offi_s5  <= offif_c[OFFI_SH +: OFFI_W];
			sensi_s5 <= sensif_c[SENSI_SH +: SENSI_W];
		end
	end

	// Stage 6: apply the corrections below 20.00 C
	always_ff @(posedge clk) begin
		if (en_s6) begin
			d1_s6   <= d1_s5;
			cold_s6 <= cold_s5;
			t_s6    <= cold_s5 ? t_s5 - $signed(T_W'(ti_s5)) : t_s5;
			off_s6  <= cold_s5 ? off_s5 - $signed(OFF_W'(offi_s5)) : off_s5;
			sens_s6 <= cold_s5 ? sens_s5 - $signed(SENS_W'(sensi_s5)) : sens_s5;
		end
	end

	assign out_valid = v_s6;
	assign mid.d1    = RAW_W'(d1_s6);
	assign mid.t     = t_s6;
	assign mid.off   = off_s6;
	assign mid.sens  = sens_s6;
	assign mid.cold  = cold_s6;

endmodule

/* rtl/core/ptc_back.sv */
module ptc_back #(
	parameter int ADC_BITS = ptc_pkg::ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ptc_pkg::ptc_mid_t                 mid,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ptc_pkg::TEMP_W-1:0] temperature_c,
	output logic signed [ptc_pkg::PRES_W-1:0] pressure_mbar,
	output logic                              cold_correction
);
	import ptc_pkg::*;

	localparam int SENS_HI_W = SENS_W - SENS_LO_W;
	localparam int PL_W      = ADC_BITS + SENS_LO_W;
	localparam int PH_W      = ADC_BITS + 1 + SENS_HI_W;
	localparam int PROD_W    = PH_W + SENS_LO_W;
	localparam int FULL_SH   = 21;
	localparam int FQ_W      = PROD_W - FULL_SH;
	localparam int A_W       = ((FQ_W > OFF_W) ? FQ_W : OFF_W) + 1;
	localparam int P_SH      = 15;
	localparam int TQ_W      = T_W + RECIP_W;
	localparam int TQ_Q_W    = TQ_W - RECIP_SH;
	localparam int PQ_W      = P_MAG_W + RECIP_W;
	localparam int PQ_Q_W    = PQ_W - RECIP_SH;
	localparam int TEMP_MAX  = (1 << (TEMP_W - 1)) - 1;
	localparam int TEMP_MIN  = -(1 << (TEMP_W - 1));

	localparam logic signed [PROD_W-1:0] FULL_RND = PROD_W'((1 << FULL_SH) - 1);
	localparam logic signed [PROD_W-1:0] F_ZERO   = PROD_W'(0);
	localparam logic signed [A_W-1:0]    P_RND    = A_W'((1 << P_SH) - 1);
	localparam logic signed [A_W-1:0]    A_ZERO   = A_W'(0);
	localparam logic signed [A_W-1:0]    P_HI     = A_W'(P_CLAMP_HI);
	localparam logic signed [A_W-1:0]    P_LO     = A_W'(P_CLAMP_LO);
	localparam logic signed [TQ_Q_W:0]   T_HI     = (TQ_Q_W+1)'(TEMP_MAX);
	localparam logic signed [TQ_Q_W:0]   T_LO     = (TQ_Q_W+1)'(TEMP_MIN);

	logic v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic en_s7, en_s8, en_s9, en_s10, en_s11, en_s12, en_s13;

	logic [ADC_BITS-1:0] d1_c;
	logic tneg_c;
	logic [T_W-1:0] tmag_c;
	logic [PL_W-1:0] pl_s7;
	logic signed [PH_W-1:0] ph_s7;
	logic [TQ_W-1:0] tq_s7;
	logic tneg_s7;
	logic signed [OFF_W-1:0] off_s7, off_s8, off_s9;
	logic cold_s7, cold_s8, cold_s9, cold_s10, cold_s11, cold_s12, cold_s13;
	logic signed [PROD_W-1:0] full_c, full_s8, full_adj;
	logic signed [TQ_Q_W:0] tquo_c, tval_c;
	logic signed [TEMP_W-1:0] temp_s8, temp_s9, temp_s10, temp_s11, temp_s12, temp_s13;
	logic signed [FQ_W-1:0] fq_s9;
	logic signed [A_W-1:0] a_s10, a_adj, pt_c, pc_c;
	logic pneg_s11, pneg_s12;
	logic [P_MAG_W-1:0] pmag_s11;
	logic [PQ_W-1:0] pq_s12;
	logic [PQ_Q_W-1:0] pquo_c;
	logic signed [PRES_W-1:0] pres_s13;

	// Advance a stage when it is empty or the next one advances
	assign en_s13   = !v_s13 || out_ready;
	assign en_s12   = !v_s12 || en_s13;
	assign en_s11   = !v_s11 || en_s12;
	assign en_s10   = !v_s10 || en_s11;
	assign en_s9    = !v_s9 || en_s10;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign in_ready = en_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			if (en_s7)  v_s7  <= in_valid;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
			if (en_s13) v_s13 <= v_s12;
		end
	end

	// Stage 7: D1 * SENS as two partial products; |TEMP| * (1/100)
	assign d1_c   = mid.d1[ADC_BITS-1:0];
	assign tneg_c = mid.t[T_W-1];
	assign tmag_c = tneg_c ? T_W'(-mid.t) : T_W'(mid.t);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			pl_s7   <= PL_W'(d1_c) * PL_W'(mid.sens[SENS_LO_W-1:0]);
			ph_s7   <= PH_W'($signed({1'b0, d1_c}))
				* PH_W'($signed(mid.sens[SENS_W-1:SENS_LO_W]));
			tq_s7   <= TQ_W'(tmag_c) * TQ_W'(RECIP_100);
			tneg_s7 <= tneg_c;
			off_s7  <= mid.off;
			cold_s7 <= mid.cold;
		end
	end

	// Stage 8: combine partial products; finish and saturate temperature
	assign full_c = (PROD_W'(ph_s7) <<< SENS_LO_W) + $signed(PROD_W'(pl_s7));
	assign tquo_c = $signed({1'b0, tq_s7[RECIP_SH +: TQ_Q_W]});
	assign tval_c = tneg_s7 ? -tquo_c : tquo_c;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			full_s8 <= full_c;
			off_s8  <= off_s7;
			cold_s8 <= cold_s7;
			if (tval_c > T_HI) begin
				temp_s8 <= TEMP_W'(T_HI);
			end else if (tval_c < T_LO) begin
				temp_s8 <= TEMP_W'(T_LO);
			end else begin
				temp_s8 <= TEMP_W'(tval_c);
			end
		end
	end

	// Stage 9: D1 * SENS / 2^21, truncated toward zero
	assign full_adj = full_s8 + (full_s8[PROD_W-1] ? FULL_RND : F_ZERO);

	always_ff @(posedge clk) begin
		if (en_s9) begin
			fq_s9   <= FQ_W'(full_adj >>> FULL_SH);
			off_s9  <= off_s8;
			cold_s9 <= cold_s8;
			temp_s9 <= temp_s8;
		end
	end

	// Stage 10: subtract OFF
	always_ff @(posedge clk) begin
		if (en_s10) begin
			a_s10    <= A_W'(fq_s9) - A_W'(off_s9);
			cold_s10 <= cold_s9;
			temp_s10 <= temp_s9;
		end
	end

	// Stage 11: P = (...) / 2^15, limit, split into sign and magnitude
	assign a_adj = a_s10 + (a_s10[A_W-1] ? P_RND : A_ZERO);
	assign pt_c  = a_adj >>> P_SH;
	assign pc_c  = (pt_c > P_HI) ? P_HI : ((pt_c < P_LO) ? P_LO : pt_c);

	always_ff @(posedge clk) begin
		if (en_s11) begin
			pneg_s11 <= pc_c[A_W-1];
			pmag_s11 <= pc_c[A_W-1] ? P_MAG_W'(-pc_c) : P_MAG_W'(pc_c);
			cold_s11 <= cold_s10;
			temp_s11 <= temp_s10;
		end
	end

	// Stage 12: |P| * (1/100)
	always_ff @(posedge clk) begin
		if (en_s12) begin
			pq_s12   <= PQ_W'(pmag_s11) * PQ_W'(RECIP_100);
			pneg_s12 <= pneg_s11;
			cold_s12 <= cold_s11;
			temp_s12 <= temp_s11;
		end
	end

	// Stage 13: restore the sign; output register, held while stalled
	assign pquo_c = pq_s12[RECIP_SH +: PQ_Q_W];

	always_ff @(posedge clk) begin
		if (en_s13) begin
			pres_s13 <= pneg_s12 ? $signed(PRES_W'(~pquo_c + 1'b1)) : $signed(PRES_W'(pquo_c));
			cold_s13 <= cold_s12;
			temp_s13 <= temp_s12;
		end
	end

	assign out_valid       = v_s13;
	assign temperature_c   = temp_s13;
	assign pressure_mbar   = pres_s13;
	assign cold_correction = cold_s13;

endmodule

/* rtl/core/pressure_temperature_compensation.sv */
// Channel  Dir  Handshake               Payload
// cfg      in   cfg_wr_en               cfg_index, cfg_data
// in       in   in_valid / in_stall     raw_pressure, raw_temperature
// out      out  out_valid / out_stall   temperature_c, pressure_mbar, cold_correction
//
// Thirteen register stages; one item is taken every cycle when the output is not
// stalled.
// The stage count is set by the D1 * SENS product, split in two partial products,
// and the two divides by 100 done as reciprocal multiplies.
// Reset clears all stage valid bits and sets every calibration word to zero.
// An output stall holds the result and backs up only through full stages, so
// in_stall rises only once every stage holds an item.
module pressure_temperature_compensation #(
	parameter int ADC_BITS = ptc_pkg::ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ptc_pkg::IDX_W-1:0]         cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ptc_pkg::RAW_W-1:0]         raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0]         raw_temperature,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ptc_pkg::TEMP_W-1:0] temperature_c,
	output logic signed [ptc_pkg::PRES_W-1:0] pressure_mbar,
	output logic                              cold_correction
);
	import ptc_pkg::*;

	ptc_cal_t cal;
	ptc_mid_t mid;
	logic     front_ready;
	logic     mid_valid;
	logic     back_ready;

	ptc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cal    (cal)
	);

	// TEMP, OFF, SENS and the cold correction
	ptc_front #(.ADC_BITS(ADC_BITS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (front_ready),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.cal             (cal),
		.out_valid       (mid_valid),
		.out_ready       (back_ready),
		.mid             (mid)
	);

	// Pressure product, scaling and saturation; temperature scaling and saturation
	ptc_back #(.ADC_BITS(ADC_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (mid_valid),
		.in_ready        (back_ready),
		.mid             (mid),
		.out_valid       (out_valid),
		.out_ready       (!out_stall),
		.temperature_c   (temperature_c),
		.pressure_mbar   (pressure_mbar),
		.cold_correction (cold_correction)
	);

	assign in_stall = !front_ready;

endmodule

/* rtl/core/ptc_checker.sv */
module ptc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [ptc_pkg::TEMP_W-1:0] temperature_c,
	input logic signed [ptc_pkg::PRES_W-1:0] pressure_mbar,
	input logic                              cold_correction
);
	import ptc_pkg::*;

	// Input backs up only when the pipeline is full behind a stalled result
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side is free");

	// Cold correction only below 20 C
	a_cold_below_ref: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cold_correction |-> temperature_c < 12'sd20)
		else $error("cold correction flagged at or above 20 C");

	// No correction means 20 C or warmer
	a_warm_at_ref: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cold_correction |-> temperature_c >= 12'sd20)
		else $error("warm item reported below 20 C");

	// A stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_mbar)
			&& $stable(temperature_c) && $stable(cold_correction))
		else $error("stalled item changed");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);
